>>> hw/rtl/lsrv_pkg.sv
// ----------------------------------------------------------------------------
// lsrv_pkg
// Types, sizes and codes shared by the LIFO stack with delete by value.
// ----------------------------------------------------------------------------
package lsrv_pkg;

    localparam int DEPTH      = 32;
    localparam int PLATE_BITS = 16;
    localparam int COUNT_BITS = $clog2(DEPTH + 1);

    // command codes
    localparam logic [1:0] CMD_PUSH   = 2'd0;
    localparam logic [1:0] CMD_POP    = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    // result status codes
    localparam logic [2:0] ST_PUSHED    = 3'd0;
    localparam logic [2:0] ST_OVERFLOW  = 3'd1;
    localparam logic [2:0] ST_POPPED    = 3'd2;
    localparam logic [2:0] ST_UNDERFLOW = 3'd3;
    localparam logic [2:0] ST_BLOCKING  = 3'd4;
    localparam logic [2:0] ST_EXIT      = 3'd5;
    localparam logic [2:0] ST_NOT_FOUND = 3'd6;

    typedef logic [PLATE_BITS-1:0] plate_t;
    typedef logic [COUNT_BITS-1:0] count_t;

    typedef struct packed {
        logic [1:0] cmd;
        plate_t     plate_in;
    } cmd_beat_t;

    typedef struct packed {
        plate_t     plate_out;
        logic [2:0] status;
        logic       last;
    } res_beat_t;

    // operation applied to every cell in the same cycle
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_PUSH,
        CELL_POP,
        CELL_COMPARE,
        CELL_STEP,
        CELL_EXIT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        plate_t   plate;
    } cell_ctl_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIND,
        S_SCAN
    } ctrl_state_t;

endpackage

>>> hw/rtl/lifo_stack_remove_by_value.sv
// ----------------------------------------------------------------------------
// lifo_stack_remove_by_value
// Bounded LIFO stack of plate numbers with push, pop and delete by value.
// ----------------------------------------------------------------------------
//  channel | valid     | ready     | beat                      | dir
//  --------+-----------+-----------+---------------------------+-----
//  command | cmd_valid | cmd_ready | cmd_beat (cmd, plate_in)  | in
//  result  | res_valid | res_ready | res_beat (plate_out,      | out
//          |           |           |   status, last)           |
//
// Push and pop each give one beat from the result register.
// Remove runs a compare step and a decide step, then gives one result
// beat per scan step (entries above the match plus the exit), the cursor
// walking the cell chain one slot per beat while the result is taken.
// A remove that finds nothing gives its beat from the decide cycle.
// Reset clears the fill count and control; entry contents are not reset.
// A stalled result holds the sequencer; a command is taken only when the
// result register is empty or its beat leaves in that same cycle.
// ----------------------------------------------------------------------------
module lifo_stack_remove_by_value
    import lsrv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  cmd_beat_t cmd_beat,
    output logic      res_valid,
    input  logic      res_ready,
    output res_beat_t res_beat
);

    cell_ctl_t          cell_ctl;
    count_t             count;
    plate_t [DEPTH-1:0] value;
    logic   [DEPTH-1:0] match;
    logic   [DEPTH-1:0] cursor;
    logic   [DEPTH-1:0] occ;
    plate_t             tap_value;
    logic               tap_match;
    logic               any_match;

    lsrv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_beat  (cmd_beat),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_beat  (res_beat),
        .top_value (value[0]),
        .any_match (any_match),
        .tap_value (tap_value),
        .tap_match (tap_match),
        .count     (count),
        .cell_ctl  (cell_ctl)
    );

    // chain of cells, slot 0 is the top of the stack
    for (genvar j = 0; j < DEPTH; j++)
    begin : g_cell
        plate_t above_value;
        plate_t below_value;
        logic   cursor_above;

        assign occ[j] = COUNT_BITS'(j) < count;

        if (j == 0)
        begin : g_top
            assign above_value  = cell_ctl.plate;
            assign cursor_above = 1'b0;
        end
        else
        begin : g_inner
            assign above_value  = value[j-1];
            assign cursor_above = cursor[j-1];
        end

        if (j == DEPTH - 1)
        begin : g_bottom
            assign below_value = '0;
        end
        else
        begin : g_upper
            assign below_value = value[j+1];
        end

        lsrv_cell u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctl          (cell_ctl),
            .seed         (j == 0),
            .occ          (occ[j]),
            .above_value  (above_value),
            .below_value  (below_value),
            .cursor_above (cursor_above),
            .value        (value[j]),
            .match        (match[j]),
            .cursor       (cursor[j])
        );
    end

    // entry under the cursor
    always_comb
    begin
        tap_value = '0;
        for (int j = 0; j < DEPTH; j++)
        begin
            tap_value = tap_value | (value[j] & {PLATE_BITS{cursor[j]}});
        end
    end

    assign tap_match = |(cursor & match);
    assign any_match = |match;

endmodule

>>> hw/rtl/lsrv_cell.sv
// ----------------------------------------------------------------------------
// lsrv_cell
// One stack slot: holds an entry, its match flag and the scan cursor.
// ----------------------------------------------------------------------------
module lsrv_cell
    import lsrv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_ctl_t ctl,
    input  logic      seed,
    input  logic      occ,
    input  plate_t    above_value,
    input  plate_t    below_value,
    input  logic      cursor_above,
    output plate_t    value,
    output logic      match,
    output logic      cursor
);

    plate_t value_reg, value_next;
    logic   match_reg, match_next;
    logic   cursor_reg, cursor_next;
    logic   visited_reg, visited_next;

    // next state of the slot
    always_comb
    begin
        value_next   = value_reg;
        match_next   = match_reg;
        cursor_next  = cursor_reg;
        visited_next = visited_reg;
        unique case (ctl.op)
            CELL_HOLD:
            begin
            end
            CELL_PUSH:
            begin
                value_next = above_value;
            end
            CELL_POP:
            begin
                value_next = below_value;
            end
            CELL_COMPARE:
            begin
                match_next   = occ && (value_reg == ctl.plate);
                cursor_next  = seed;
                visited_next = 1'b0;
            end
            CELL_STEP:
            begin
                cursor_next  = cursor_above;
                visited_next = visited_reg | cursor_reg;
            end
            CELL_EXIT:
            begin
                // the match and everything below it close the gap
                if (cursor_reg || !visited_reg)
                begin
                    value_next = below_value;
                end
                cursor_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    // entry storage, no reset
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    // scan control bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg   <= 1'b0;
            cursor_reg  <= 1'b0;
            visited_reg <= 1'b0;
        end
        else
        begin
            match_reg   <= match_next;
            cursor_reg  <= cursor_next;
            visited_reg <= visited_next;
        end
    end

    assign value  = value_reg;
    assign match  = match_reg;
    assign cursor = cursor_reg;

endmodule

>>> hw/rtl/lsrv_ctrl.sv
// ----------------------------------------------------------------------------
// lsrv_ctrl
// Command sequencer, fill count and result register for the cell chain.
// ----------------------------------------------------------------------------
module lsrv_ctrl
    import lsrv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  cmd_beat_t cmd_beat,
    output logic      res_valid,
    input  logic      res_ready,
    output res_beat_t res_beat,
    input  plate_t    top_value,
    input  logic      any_match,
    input  plate_t    tap_value,
    input  logic      tap_match,
    output count_t    count,
    output cell_ctl_t cell_ctl
);

    ctrl_state_t state_reg, state_next;
    count_t      count_reg, count_next;
    plate_t      key_reg, key_next;
    logic        out_valid_reg, out_valid_next;
    res_beat_t   out_reg, out_next;

    logic out_free;
    logic accept;

    assign out_free  = !out_valid_reg || res_ready;
    assign cmd_ready = (state_reg == S_IDLE) && out_free;
    assign accept    = cmd_valid && cmd_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && cmd_beat.cmd == CMD_REMOVE)
                begin
                    state_next = S_FIND;
                end
            end
            S_FIND:
            begin
                if (any_match)
                begin
                    state_next = S_SCAN;
                end
                else if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (out_free && tap_match)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs: cell operation, fill count and result beat
    always_comb
    begin
        count_next     = count_reg;
        key_next       = key_reg;
        out_valid_next = out_valid_reg && !res_ready;
        out_next       = out_reg;
        cell_ctl.op    = CELL_HOLD;
        cell_ctl.plate = cmd_beat.plate_in;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    key_next = cmd_beat.plate_in;
                    unique case (cmd_beat.cmd)
                        CMD_PUSH:
                        begin
                            out_valid_next     = 1'b1;
                            out_next.plate_out = cmd_beat.plate_in;
                            out_next.last      = 1'b1;
                            if (count_reg == COUNT_BITS'(DEPTH))
                            begin
                                out_next.status = ST_OVERFLOW;
                            end
                            else
                            begin
                                out_next.status = ST_PUSHED;
                                cell_ctl.op     = CELL_PUSH;
                                count_next      = count_reg + 1'b1;
                            end
                        end
                        CMD_POP:
                        begin
                            out_valid_next = 1'b1;
                            out_next.last  = 1'b1;
                            if (count_reg == '0)
                            begin
                                out_next.status    = ST_UNDERFLOW;
                                out_next.plate_out = '0;
                            end
                            else
                            begin
                                out_next.status    = ST_POPPED;
                                out_next.plate_out = top_value;
                                cell_ctl.op        = CELL_POP;
                                count_next         = count_reg - 1'b1;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            cell_ctl.op = CELL_COMPARE;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_FIND:
            begin
                if (!any_match && out_free)
                begin
                    out_valid_next     = 1'b1;
                    out_next.plate_out = key_reg;
                    out_next.status    = ST_NOT_FOUND;
                    out_next.last      = 1'b1;
                end
            end
            S_SCAN:
            begin
                if (out_free)
                begin
                    out_valid_next     = 1'b1;
                    out_next.plate_out = tap_value;
                    out_next.last      = tap_match;
                    if (tap_match)
                    begin
                        out_next.status = ST_EXIT;
                        cell_ctl.op     = CELL_EXIT;
                        count_next      = count_reg - 1'b1;
                    end
                    else
                    begin
                        out_next.status = ST_BLOCKING;
                        cell_ctl.op     = CELL_STEP;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        out_reg <= out_next;
    end

    assign res_valid = out_valid_reg;
    assign res_beat  = out_reg;
    assign count     = count_reg;

endmodule
